@@ hw/rtl/rau_pkg.sv @@
// rau_pkg: shared types and constants of the rational arithmetic unit
// no dependencies; used by rau_front, rau_back and the top level
package rau_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned DenWidth = InWidth - 1;
  localparam int unsigned WWidth   = 64;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  // classified transaction handed from front to back
  typedef struct packed {
    op_e                 op;
    logic                neg_a;
    logic                neg_b;
    logic [InWidth-1:0]  mag_a;
    logic [DenWidth-1:0] den_a;
    logic [InWidth-1:0]  mag_b;
    logic [DenWidth-1:0] den_b;
  } item_t;

endpackage

@@ hw/rtl/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: fraction add/sub/mul/div with gcd reduction
// a zero mul/div result skips all divisions; every other result runs euclid and
// divisions on the shared bit-serial divider, each euclid step being one full division
// throughput is one transaction per back-end run; a 2-entry queue decouples start
// reset is asynchronous active low and clears queue and sequencer; results cannot stall
module rational_arithmetic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic signed [rau_pkg::InWidth-1:0]  num_a_i,
  input  logic [rau_pkg::DenWidth-1:0] den_a_i,
  input  logic signed [rau_pkg::InWidth-1:0]  num_b_i,
  input  logic [rau_pkg::DenWidth-1:0] den_b_i,
  output logic                         res_valid_o,
  output logic signed [31:0]           res_num_o,
  output logic [30:0]                  res_den_o,
  output logic                         div_zero_o
);
  logic           q_valid, pop, full;
  rau_pkg::item_t item;

  rau_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i,
    .num_a_i(num_a_i), .den_a_i, .num_b_i(num_b_i), .den_b_i,
    .full_o(full), .pop_i(pop), .valid_o(q_valid), .item_o(item)
  );

  rau_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(item), .pop_o(pop),
    .done_o(res_valid_o), .res_num_o, .res_den_o, .div_zero_o
  );

  assign busy = full;
endmodule

@@ hw/rtl/rau_front.sv @@
// rau_front: accepts a transaction, splits signs and fixes zero denominators,
// and keeps a two-entry queue for the back end; uses rau_pkg
module rau_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [1:0]                     cmd_i,
  input  logic [rau_pkg::InWidth-1:0]    num_a_i,
  input  logic [rau_pkg::DenWidth-1:0]   den_a_i,
  input  logic [rau_pkg::InWidth-1:0]    num_b_i,
  input  logic [rau_pkg::DenWidth-1:0]   den_b_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           valid_o,
  output rau_pkg::item_t                 item_o
);

  rau_pkg::item_t q_mem_q [rau_pkg::QDepth];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  rau_pkg::item_t cls;
  logic           push;

  always_comb begin
    cls.op    = rau_pkg::op_e'(cmd_i);
    cls.neg_a = num_a_i[rau_pkg::InWidth-1];
    cls.neg_b = num_b_i[rau_pkg::InWidth-1];
    cls.mag_a = cls.neg_a ? (~num_a_i + 1'b1) : num_a_i;
    cls.mag_b = cls.neg_b ? (~num_b_i + 1'b1) : num_b_i;
    cls.den_a = (den_a_i == '0) ? rau_pkg::DenWidth'(1) : den_a_i;
    cls.den_b = (den_b_i == '0) ? rau_pkg::DenWidth'(1) : den_b_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign push    = start_i && !full_o;
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/rau_back.sv @@
// rau_back: sequencer with one shared bit-serial divider for gcd, lcm and
// reduction, plus two 32x32 multipliers; uses rau_pkg
module rau_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  rau_pkg::item_t        item_i,
  output logic                  pop_o,
  output logic                  done_o,
  output logic [31:0]           res_num_o,
  output logic [30:0]           res_den_o,
  output logic                  div_zero_o
);
  localparam int unsigned W = rau_pkg::WWidth;

  typedef enum logic [3:0] {
    SIdle, SGcdD, SLcmA, SLcmB, SCombine, SMul, SGcdR, SRedN, SRedD, SOut, SDiv
  } state_e;

  state_e         state_q, ret_q;
  rau_pkg::item_t it_q;
  logic [W-1:0]   x_q, y_q, g_q, lcm_q, ta_q, mag_q, den_q;
  logic           neg_q, err_q;
  // divider
  logic [W-1:0]   dvd_q, dvs_q, quo_q, rem_q;
  logic [6:0]     cnt_q;
  logic [W:0]     trial;
  logic [W-1:0]   rem_sh;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mul_p;
  logic [31:0]    mul2_a, mul2_b;
  logic [63:0]    mul2_p;
  logic [31:0]    num_out;
  logic [30:0]    den_out;
  logic           nb_eff;

  assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
  assign mul_p  = mul_a * mul_b;
  assign mul2_p = mul2_a * mul2_b;
  assign nb_eff = (it_q.op == rau_pkg::OpSub) ? !it_q.neg_b : it_q.neg_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul2_a = '0;
    mul2_b = '0;
    case (state_q)
      SLcmA:   begin mul_a = 32'(quo_q); mul_b = 32'(it_q.den_b); end
      SCombine: begin
        mul_a = 32'(ta_q); mul_b = 32'(it_q.mag_a);
        mul2_a = 32'(quo_q); mul2_b = 32'(it_q.mag_b);
      end
      SMul: begin
        mul2_a = 32'(it_q.den_a);
        if (it_q.op == rau_pkg::OpMul) begin
          mul_a = 32'(it_q.mag_a); mul_b = 32'(it_q.mag_b);
          mul2_b = 32'(it_q.den_b);
        end else begin
          mul_a = 32'(it_q.mag_a); mul_b = 32'(it_q.den_b);
          mul2_b = 32'(it_q.mag_b);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_q) num_out = (mag_q > 64'h8000_0000) ? 32'h8000_0000 : (~mag_q[31:0] + 1'b1);
    else       num_out = (mag_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_q[31:0];
    den_out = (den_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : den_q[30:0];
  end

  assign pop_o = (state_q == SIdle) && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ret_q   <= SIdle;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        SIdle: if (valid_i) begin
          it_q <= item_i;
          err_q <= 1'b0;
          x_q <= W'(item_i.den_a);
          y_q <= W'(item_i.den_b);
          if (item_i.op == rau_pkg::OpAdd || item_i.op == rau_pkg::OpSub) begin
            state_q <= SGcdD;
          end else state_q <= SMul;
        end
        // euclid on x_q, y_q via the divider; g_q gets the result, then den_a or mag_q is divided by it
        SGcdD, SGcdR: begin
          if (y_q == '0) begin
            g_q <= x_q;
            if (state_q == SGcdD) begin
              dvd_q <= W'(it_q.den_a); dvs_q <= x_q; ret_q <= SLcmA;
            end else begin
              dvd_q <= mag_q; dvs_q <= x_q; ret_q <= SRedN;
            end
            rem_q <= '0; quo_q <= '0; cnt_q <= 7'(W);
            state_q <= SDiv;
          end else begin
            dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; quo_q <= '0;
            cnt_q <= 7'(W);
            ret_q <= state_q;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (cnt_q == '0) begin
            state_q <= ret_q;
            if (ret_q == SGcdD || ret_q == SGcdR) begin
              x_q <= y_q; y_q <= rem_q;
            end
          end else begin
            dvd_q <= {dvd_q[W-2:0], 1'b0};
            if (!trial[W]) begin
              rem_q <= trial[W-1:0]; quo_q <= {quo_q[W-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh; quo_q <= {quo_q[W-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
          end
        end
        SLcmA: begin
          lcm_q <= mul_p;
          dvd_q <= mul_p; dvs_q <= W'(it_q.den_a);
          rem_q <= '0; quo_q <= '0; cnt_q <= 7'(W);
          ret_q <= SLcmB; state_q <= SDiv;
        end
        SLcmB: begin
          // quo_q = lcm/den_a; next lcm/den_b
          ta_q <= quo_q;
          dvd_q <= lcm_q; dvs_q <= W'(it_q.den_b);
          rem_q <= '0; quo_q <= '0; cnt_q <= 7'(W);
          ret_q <= SCombine; state_q <= SDiv;
        end
        SCombine: begin : comb_blk
          logic [W-1:0] ta, tb;
          ta = mul_p;
          tb = mul2_p;
          den_q <= lcm_q;
          if (it_q.neg_a == nb_eff) begin
            mag_q <= ta + tb; neg_q <= it_q.neg_a;
          end else if (ta >= tb) begin
            mag_q <= ta - tb; neg_q <= it_q.neg_a;
          end else begin
            mag_q <= tb - ta; neg_q <= nb_eff;
          end
          state_q <= SRedD;
          ret_q <= SIdle;
        end
        SMul: begin
          neg_q <= it_q.neg_a != it_q.neg_b;
          mag_q <= mul_p;
          den_q <= mul2_p;
          if (it_q.op == rau_pkg::OpDiv && it_q.mag_b == '0) begin
            err_q <= 1'b1; mag_q <= '0;
          end
          state_q <= SRedD;
          ret_q <= SIdle;
        end
        // entry to reduction: zero check, then gcd
        SRedD: begin
          if (mag_q == '0) begin
            den_q <= 64'd1; neg_q <= 1'b0; state_q <= SOut;
          end else begin
            x_q <= mag_q; y_q <= den_q; state_q <= SGcdR;
          end
        end
        SRedN: begin
          mag_q <= quo_q;
          dvd_q <= den_q; dvs_q <= g_q;
          rem_q <= '0; quo_q <= '0; cnt_q <= 7'(W);
          ret_q <= SOut; state_q <= SDiv;
        end
        SOut: begin
          if (ret_q == SOut) den_q <= quo_q;
          ret_q <= SIdle;
          state_q <= SIdle;
          done_o <= 1'b1;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign res_num_o  = num_out;
  assign res_den_o  = den_out;
  assign div_zero_o = err_q;

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == SIdle) else $error("pop outside idle");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv && cnt_q == 7'(W)) |-> dvs_q != '0) else $error("divide by zero");
`endif

endmodule

@@ verif/rational_arithmetic_unit_tb.sv @@
// rational_arithmetic_unit_tb: self-checking testbench for the fraction arithmetic unit
// depends on rau_pkg and rational_arithmetic_unit; predicts each reduced fraction itself
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;

  localparam int unsigned CycleLimit = 30_000_000;
  localparam int unsigned DrainCycles = 6000;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               dz;
  } fraction_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic [1:0]                          cmd_i;
  logic signed [rau_pkg::InWidth-1:0]  num_a_i;
  logic [rau_pkg::DenWidth-1:0]        den_a_i;
  logic signed [rau_pkg::InWidth-1:0]  num_b_i;
  logic [rau_pkg::DenWidth-1:0]        den_b_i;
  logic                                res_valid_o;
  logic signed [31:0]                  res_num_o;
  logic [30:0]                         res_den_o;
  logic                                div_zero_o;

  fraction_t   pending_fractions[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_gaps;

  rational_arithmetic_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .num_a_i     (num_a_i),
    .den_a_i     (den_a_i),
    .num_b_i     (num_b_i),
    .den_b_i     (den_b_i),
    .res_valid_o (res_valid_o),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .div_zero_o  (div_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic fraction_t reduced_fraction(rau_pkg::op_e op,
      logic [rau_pkg::InWidth-1:0] na_raw, logic [rau_pkg::DenWidth-1:0] da_raw,
      logic [rau_pkg::InWidth-1:0] nb_raw, logic [rau_pkg::DenWidth-1:0] db_raw);
    logic [rau_pkg::InWidth-1:0] na_neg, nb_neg;
    logic [63:0] ma, mb, da, db, g, lcm, ta, tb, mag, den;
    logic sa, sb, neg;
    fraction_t r;
    na_neg = ~na_raw + 1'b1;
    nb_neg = ~nb_raw + 1'b1;
    sa = na_raw[rau_pkg::InWidth-1];
    sb = nb_raw[rau_pkg::InWidth-1];
    ma = sa ? 64'(na_neg) : 64'(na_raw);
    mb = sb ? 64'(nb_neg) : 64'(nb_raw);
    // a zero denominator counts as one
    da = (da_raw == 0) ? 64'd1 : 64'(da_raw);
    db = (db_raw == 0) ? 64'd1 : 64'(db_raw);
    mag = 0;
    den = 1;
    neg = 1'b0;
    r.dz = 1'b0;
    case (op)
      rau_pkg::OpAdd, rau_pkg::OpSub: begin
        g = euclid_gcd(da, db);
        lcm = (da / g) * db;
        ta = (lcm / da) * ma;
        tb = (lcm / db) * mb;
        if (op == rau_pkg::OpSub) sb = ~sb;
        if (sa == sb) begin
          mag = ta + tb;
          neg = sa;
        end else if (ta >= tb) begin
          mag = ta - tb;
          neg = sa;
        end else begin
          mag = tb - ta;
          neg = sb;
        end
        den = lcm;
      end
      rau_pkg::OpMul: begin
        mag = ma * mb;
        den = da * db;
        neg = sa != sb;
      end
      default: begin
        if (mb == 0) begin
          r.dz = 1'b1;
        end else begin
          mag = ma * db;
          den = da * mb;
          neg = sa != sb;
        end
      end
    endcase
    if (mag == 0) begin
      den = 1;
      neg = 1'b0;
    end else begin
      g = euclid_gcd(mag, den);
      mag = mag / g;
      den = den / g;
    end
    if (den > 64'h7FFF_FFFF) den = 64'h7FFF_FFFF;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.num = -mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      r.num = mag[31:0];
    end
    r.den = den[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint expected, longint got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d",
             cycle_count, field, expected, got);
    error_count++;
  endtask

  // result checker: the unit cannot be stalled, so every strobe is one transaction
  always @(posedge clk_i) begin
    fraction_t e;
    if (rst_ni && res_valid_o) begin
      if (pending_fractions.size() == 0) begin
        $display("unexpected result at cycle %0d: %0d/%0d", cycle_count,
                 res_num_o, res_den_o);
        error_count++;
      end else begin
        e = pending_fractions.pop_front();
        if (res_num_o !== e.num) report_mismatch("res_num", e.num, res_num_o);
        if (res_den_o !== e.den) report_mismatch("res_den", e.den, res_den_o);
        if (div_zero_o !== e.dz) report_mismatch("div_zero", e.dz, div_zero_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_fractions.size());
      $display("simulation failed");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_fraction_pair(rau_pkg::op_e op, logic [rau_pkg::InWidth-1:0] na,
      logic [rau_pkg::DenWidth-1:0] da, logic [rau_pkg::InWidth-1:0] nb,
      logic [rau_pkg::DenWidth-1:0] db);
    cmd_i   = op;
    num_a_i = na;
    den_a_i = da;
    num_b_i = nb;
    den_b_i = db;
    start   = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_fractions.push_back(reduced_fraction(op, na, da, nb, db));
    @(negedge clk_i);
    if (!no_gaps && $urandom_range(99) < 33) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic test_extremes();
    rau_pkg::op_e op;
    for (int i = 0; i < 4; i++) begin
      op = rau_pkg::op_e'(i);
      send_fraction_pair(op, 16'h7FFF, 15'h7FFF, 16'h7FFF, 15'd1);
      send_fraction_pair(op, 16'h8000, 15'd1, 16'h8000, 15'd1);
      send_fraction_pair(op, 16'h8000, 15'h7FFF, 16'h7FFF, 15'h7FFE);
      send_fraction_pair(op, 16'hFFFF, 15'd1, 16'h0001, 15'h7FFF);
    end
  endtask

  task automatic test_special_cases();
    send_fraction_pair(rau_pkg::OpDiv, 16'd5, 15'd7, 16'd0, 15'd3);  // divide by zero fraction
    send_fraction_pair(rau_pkg::OpDiv, 16'd0, 15'd7, 16'd0, 15'd9);
    send_fraction_pair(rau_pkg::OpSub, 16'd3, 15'd4, 16'd6, 15'd8);  // difference is zero
    send_fraction_pair(rau_pkg::OpMul, 16'd0, 15'd5, 16'h8000, 15'd3);
    send_fraction_pair(rau_pkg::OpAdd, 16'd3, 15'd0, 16'd1, 15'd0);  // zero denominators
    send_fraction_pair(rau_pkg::OpDiv, 16'hFFFE, 15'd0, 16'd4, 15'd6);
  endtask

  task automatic send_random_item();
    logic [rau_pkg::InWidth-1:0] na, nb;
    logic [rau_pkg::DenWidth-1:0] da, db;
    na = rau_pkg::InWidth'($urandom);
    nb = rau_pkg::InWidth'($urandom);
    da = rau_pkg::DenWidth'($urandom);
    db = rau_pkg::DenWidth'($urandom);
    // small operands give zero results and heavy reduction
    if ($urandom_range(3) == 0) na = rau_pkg::InWidth'($urandom_range(20) - 10);
    if ($urandom_range(3) == 0) nb = rau_pkg::InWidth'($urandom_range(20) - 10);
    if ($urandom_range(3) == 0) da = rau_pkg::DenWidth'($urandom_range(24));
    if ($urandom_range(3) == 0) db = rau_pkg::DenWidth'($urandom_range(24));
    if ($urandom_range(15) == 0) nb = '0;
    send_fraction_pair(rau_pkg::op_e'($urandom_range(3)), na, da, nb, db);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_random_item();
  endtask

  task automatic test_back_to_back(int unsigned count);
    no_gaps = 1'b1;
    test_random(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    no_gaps = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = rau_pkg::OpAdd;
    num_a_i = '0;
    den_a_i = '0;
    num_b_i = '0;
    den_b_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_special_cases();
    test_random(500);
    test_back_to_back(200);
    test_random(380);
    start = 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
